[design/feistel_mod257_block_cipher_unit_assert.svh]
// assertion macros shared by the cipher rtl
`ifndef FEISTEL_MOD257_BLOCK_CIPHER_UNIT_ASSERT_SVH
`define FEISTEL_MOD257_BLOCK_CIPHER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define FMBC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fmbc assertion failed");
// next-cycle implication, checked outside reset
`define FMBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fmbc assertion failed");
// next-cycle implication, also checked through reset
`define FMBC_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fmbc assertion failed");
`else
`define FMBC_ASSERT_IMPL(label, ante, cons)
`define FMBC_ASSERT_NEXT(label, ante, cons)
`define FMBC_ASSERT_RST(label, ante, cons)
`endif
`endif

[design/fmbc_pkg.sv]
// shared constants, s-box table and p-box for the feistel cipher
package fmbc_pkg;

  localparam int RoundCount = 8;
  localparam int FieldMod   = 257;
  localparam int AffMul     = 127;
  localparam int AffAdd     = 225;

  typedef logic [255:0][7:0] sbox_table_t;

  // register indexes of the config port
  typedef enum logic [0:0] {
    CFG_CIPHER_KEY   = 1'b0,
    CFG_DECRYPT_MODE = 1'b1
  } cfg_index_t;

  // destination position (1 = msb) of source bits 1..16
  localparam int PBOX_DEST [16] = '{9, 5, 3, 2, 13, 7, 4, 14, 11, 6, 15, 8, 16, 12, 10, 1};

  // elaboration-time table: z = 127 * x^-1 + 225 mod 257, zero byte taken as 256
  function automatic sbox_table_t build_sbox();
    sbox_table_t t;
    int xv;
    int r;
    int b;
    int z;
    for (int x = 0; x < 256; x++) begin
      xv = (x == 0) ? 256 : x;
      r  = 1;
      b  = xv;
      // exponent 255 is all ones over eight bits
      for (int k = 0; k < 8; k++) begin
        r = (r * b) % FieldMod;
        b = (b * b) % FieldMod;
      end
      z = (AffMul * r + AffAdd) % FieldMod;
      if (z == 256) begin
        z = 0;
      end
      t[x] = 8'(z);
    end
    return t;
  endfunction

  localparam sbox_table_t SBOX = build_sbox();

  function automatic logic [15:0] pbox(input logic [15:0] v);
    logic [15:0] o;
    o = '0;
    for (int i = 0; i < 16; i++) begin
      o[16 - PBOX_DEST[i]] = v[15 - i];
    end
    return o;
  endfunction

  function automatic logic [31:0] swap_halves(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

endpackage

[design/fmbc_stage.sv]
// one feistel round as a pipeline stage with valid bit and stall handling
module fmbc_stage (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  logic [31:0] up_data,    // left half upper, right half lower
  input  logic [15:0] round_key,
  output logic        dn_valid,
  input  logic        dn_ready,
  output logic [31:0] dn_data
);

  logic        valid_r;
  logic [31:0] data_r;
  logic [31:0] data_nxt;
  logic [15:0] left_w;
  logic [15:0] right_w;
  logic [7:0]  x_hi;
  logic [7:0]  x_lo;
  logic [15:0] f_out;
  logic        advance;

  assign advance  = !valid_r || dn_ready;
  assign up_ready = advance;

  always_comb begin
    left_w   = up_data[31:16];
    right_w  = up_data[15:0];
    x_hi     = right_w[15:8] ^ round_key[15:8];
    x_lo     = right_w[7:0] ^ round_key[7:0];
    f_out    = fmbc_pkg::pbox({fmbc_pkg::SBOX[x_hi], fmbc_pkg::SBOX[x_lo]});
    data_nxt = {right_w, left_w ^ f_out};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

[design/feistel_mod257_block_cipher_unit.sv]
// eight-round feistel cipher over mod-257 s-boxes, one round per register stage
// an accepted block passes through one register per round on its way to out_tvalid
// throughput: one 32-bit block per cycle unless stalled; a stall holds full stages while empty ones fill
// reset (rst_n low, synchronous): all stage valid bits cleared, key and mode set to 0
// key and mode are read by every stage directly, so write them only while empty
module feistel_mod257_block_cipher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // [31:0] block_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // [31:0] block_out
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_addr,
  input  logic [31:0] cfg_wr_data
);

  `include "feistel_mod257_block_cipher_unit_assert.svh"

  localparam int NStages = fmbc_pkg::RoundCount;

  logic [31:0] cipher_key_r;
  logic        decrypt_mode_r;

  logic [NStages:0]       stg_valid;
  logic [NStages:0]       stg_ready;
  logic [31:0]            stg_data [NStages+1];
  logic [63:0]            key_dbl;
  logic [15:0]            rkey [NStages];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cipher_key_r   <= '0;
      decrypt_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (fmbc_pkg::cfg_index_t'(cfg_addr))
        fmbc_pkg::CFG_CIPHER_KEY:   cipher_key_r   <= cfg_wr_data;
        fmbc_pkg::CFG_DECRYPT_MODE: decrypt_mode_r <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  assign key_dbl = {cipher_key_r, cipher_key_r};

  // round key i is the upper half of the key rotated left by 4(i-1); decrypt mode uses the keys in reverse order
  for (genvar g = 0; g < NStages; g++) begin : g_round
    localparam int EncShift = 4 * g;
    localparam int DecShift = 4 * (NStages - 1 - g);
    assign rkey[g] = decrypt_mode_r ? key_dbl[63-DecShift -: 16] : key_dbl[63-EncShift -: 16];

    fmbc_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (stg_valid[g]),
      .up_ready  (stg_ready[g]),
      .up_data   (stg_data[g]),
      .round_key (rkey[g]),
      .dn_valid  (stg_valid[g+1]),
      .dn_ready  (stg_ready[g+1]),
      .dn_data   (stg_data[g+1])
    );
  end

  assign stg_valid[0] = in_tvalid;
  assign in_tready    = stg_ready[0];
  assign stg_data[0]  = decrypt_mode_r ? fmbc_pkg::swap_halves(in_tdata) : in_tdata;

  assign out_tvalid         = stg_valid[NStages];
  assign stg_ready[NStages] = out_tready;
  assign out_tdata = decrypt_mode_r ? fmbc_pkg::swap_halves(stg_data[NStages])
                                    : stg_data[NStages];

  // the pipeline only pushes back when the output item is held
  `FMBC_ASSERT_IMPL(a_stall_from_out, !in_tready, out_tvalid && !out_tready)
  // an accepted item lands in the first round stage
  `FMBC_ASSERT_NEXT(a_accept_first, in_tvalid && in_tready, stg_valid[1])
  // a free output register never backs up the input
  `FMBC_ASSERT_IMPL(a_out_free_ready, !out_tvalid, in_tready)
  // reset leaves no result pending
  `FMBC_ASSERT_RST(a_reset_empty, !rst_n, !out_tvalid)

endmodule
